### hw/rtl/yfdm_pkg.sv
// Shared constants, configuration register codes and mixing functions
// for the YUY2 frame downscale mixer. No dependencies.
`default_nettype none

package yfdm_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 350;
  localparam int WORD_W       = 32;

  localparam int ROW_WORDS     = FRAME_WIDTH / 2;
  localparam int ROWS_HALVED   = (FRAME_HEIGHT / 2) * 2;
  localparam int COL_W         = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int ROW_W         = $clog2(FRAME_HEIGHT);
  localparam int CFG_IDX_W     = 3;

  localparam logic [COL_W-1:0] COL_LAST       = COL_W'(ROW_WORDS - 1);
  localparam logic [ROW_W:0]   ROWS_FULL      = (ROW_W + 1)'(FRAME_HEIGHT);
  localparam logic [ROW_W:0]   ROWS_PAIRED    = (ROW_W + 1)'(ROWS_HALVED);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDE      = 3'd0,
    REG_HALVE_ROWS       = 3'd1,
    REG_LUMA_FIRST_MASK  = 3'd2,
    REG_LUMA_SECOND_MASK = 3'd3,
    REG_CHROMA_MASK      = 3'd4
  } cfg_reg_t;

  typedef logic [WORD_W-1:0] word_t;

  // Halve both masked fields, add, and mask again.
  function automatic word_t avg_field(word_t a, word_t b, word_t m);
    word_t sum;
    sum = ((a & m) >> 1) + ((b & m) >> 1);
    return sum & m;
  endfunction

  function automatic word_t mix_pair(word_t first, word_t second, word_t l1m,
                                     word_t l2m, word_t cm);
    return (first & l1m) | (second & l2m) | avg_field(first, second, cm);
  endfunction

  function automatic word_t mix_rows(word_t upper, word_t lower, word_t l1m,
                                     word_t l2m, word_t cm);
    return avg_field(upper, lower, l1m) | avg_field(upper, lower, l2m) |
           avg_field(upper, lower, cm);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/yfdm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module yfdm_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 320,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/yuy2_frame_downscale_mixer.sv
// YUY2 frame downscale mixer: pair merge, row averaging through a line store.
// A word that produces output passes stage 1, then the output register, to out_tvalid.
// Throughput: one word per clock if not stalled; line store: one write and one read port.
// Reset (rst_n low, synchronous): counters, pair phase, pipeline valids and config registers
// return to defaults. The line store is not cleared and needs no clearing pass.
// Depends on yfdm_pkg and yfdm_ram.
`default_nettype none

module yuy2_frame_downscale_mixer
  import yfdm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata,
  // source words
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [WORD_W-1:0]    in_tdata,   // [31:0] pixel_word
  input  wire logic                 in_tuser,   // [0] frame_start
  // packed output words
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [WORD_W-1:0]    out_tdata,  // [31:0] out_word
  output logic                      out_tlast   // last_in_frame
);

  // configuration
  logic  source_wide_r, halve_rows_r;
  word_t luma_first_mask_r, luma_second_mask_r, chroma_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_wide_r      <= 1'b0;
      halve_rows_r       <= 1'b0;
      luma_first_mask_r  <= 32'hFF00_0000;
      luma_second_mask_r <= 32'h0000_FF00;
      chroma_mask_r      <= 32'h00FF_00FF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDE:      source_wide_r      <= cfg_wdata[0];
        REG_HALVE_ROWS:       halve_rows_r       <= cfg_wdata[0];
        REG_LUMA_FIRST_MASK:  luma_first_mask_r  <= cfg_wdata;
        REG_LUMA_SECOND_MASK: luma_second_mask_r <= cfg_wdata;
        REG_CHROMA_MASK:      chroma_mask_r      <= cfg_wdata;
        default:              ;
      endcase
    end
  end

  // front state
  logic             phase_r, phase_nxt;
  word_t            hold_r, hold_nxt;
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic             phase_cur;

  // stage 1 and output register
  logic             s1_valid_r, s1_mix_r, s1_last_r;
  word_t            s1_word_r;
  logic             out_valid_r, out_last_r;
  word_t            out_word_r;
  word_t            store_rdata;

  logic             take, s1_move, out_free;
  logic             pair_done, store_row, emit;
  logic             last_cur;
  word_t            merged;
  logic [ROW_W:0]   rows_sel, row_inc;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_move;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    // frame start clears the counters before the word is taken
    col_cur   = in_tuser ? '0 : col_r;
    row_cur   = in_tuser ? '0 : row_r;
    phase_cur = in_tuser ? 1'b0 : phase_r;
    rows_sel  = halve_rows_r ? ROWS_PAIRED : ROWS_FULL;
    row_inc   = {1'b0, row_cur} + 1'b1;

    pair_done = !source_wide_r || phase_cur;
    merged    = source_wide_r ? mix_pair(hold_r, in_tdata, luma_first_mask_r,
                                         luma_second_mask_r, chroma_mask_r)
                              : in_tdata;
    store_row = halve_rows_r && !row_cur[0];
    emit      = pair_done && !store_row;
    last_cur  = ({1'b0, row_cur} == rows_sel - 1'b1) && (col_cur == COL_LAST);

    hold_nxt  = hold_r;
    phase_nxt = phase_cur;
    col_nxt   = col_cur;
    row_nxt   = row_cur;
    if (!pair_done) begin
      // hold the first word of a pair
      hold_nxt  = in_tdata;
      phase_nxt = 1'b1;
    end else begin
      // a narrow source word leaves the pair phase alone
      phase_nxt = phase_cur && !source_wide_r;
      if (col_cur == COL_LAST) begin
        col_nxt = '0;
        row_nxt = (row_inc >= rows_sel) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      hold_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // even rows write the line store, odd rows read back the same column
  yfdm_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (ROW_WORDS)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (take && pair_done && store_row),
    .wr_addr   (col_cur),
    .wr_data   (merged),
    .rd_en     (take && emit),
    .rd_addr   (col_cur),
    .rd_data_r (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take && emit) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
    if (take && emit) begin
      s1_word_r <= merged;
      s1_mix_r  <= halve_rows_r;
      s1_last_r <= last_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_move) begin
      out_word_r <= s1_mix_r ? mix_rows(store_rdata, s1_word_r, luma_first_mask_r,
                                        luma_second_mask_r, chroma_mask_r)
                             : s1_word_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### tb/yfdm_display_checker.sv
// Checker for the YUY2 frame downscale mixer: follows register writes and accepted
// source words, predicts each display word and compares it with the output channel.
// Depends on yfdm_pkg.
module yfdm_display_checker
  import yfdm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [WORD_W-1:0]    in_tdata,   // [31:0] pixel_word
  input  logic                 in_tuser,   // [0] frame_start
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [WORD_W-1:0]    out_tdata,  // [31:0] out_word
  input  logic                 out_tlast,  // last_in_frame
  output int                   outstanding,
  output int                   errors
);

  typedef struct packed {
    word_t word;
    logic  last;
  } display_word_t;

  // Register copies
  logic  src_wide;
  logic  row_halving;
  word_t mask_luma_a;
  word_t mask_luma_b;
  word_t mask_chroma;

  // Counter and store copies
  word_t       pair_first;
  logic        pair_open;
  int unsigned col_pos;
  int unsigned row_pos;
  word_t       row_copy [ROW_WORDS];

  display_word_t display_due [$];

  // Halve each masked field, add, and keep only the field bits.
  function automatic word_t halve_blend(input word_t a, input word_t b, input word_t m);
    word_t half_a;
    word_t half_b;
    half_a = (a & m) >> 1;
    half_b = (b & m) >> 1;
    return (half_a + half_b) & m;
  endfunction

  // Advance the counter copies by one source word; return 1 when a display word is due.
  function automatic bit predict_display_word(input word_t src, input logic start,
                                              output display_word_t item);
    word_t       merged;
    int unsigned frame_rows;
    bit          emits;
    emits = 1'b0;
    item = '0;
    frame_rows = row_halving ? (FRAME_HEIGHT / 2) * 2 : FRAME_HEIGHT;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
      pair_open = 1'b0;
    end
    if (src_wide && !pair_open) begin
      pair_first = src;
      pair_open = 1'b1;
      return 1'b0;
    end
    if (src_wide) begin
      pair_open = 1'b0;
      merged = (pair_first & mask_luma_a) | (src & mask_luma_b) |
               halve_blend(pair_first, src, mask_chroma);
    end else begin
      merged = src;
    end
    if (col_pos >= ROW_WORDS) col_pos = 0;
    if (row_halving && (row_pos % 2) == 0) begin
      row_copy[col_pos] = merged;
    end else begin
      if (row_halving) begin
        item.word = halve_blend(row_copy[col_pos], merged, mask_luma_a) |
                    halve_blend(row_copy[col_pos], merged, mask_luma_b) |
                    halve_blend(row_copy[col_pos], merged, mask_chroma);
      end else begin
        item.word = merged;
      end
      item.last = (row_pos == frame_rows - 1) && (col_pos == ROW_WORDS - 1);
      emits = 1'b1;
    end
    col_pos++;
    if (col_pos >= ROW_WORDS) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= frame_rows) row_pos = 0;
    end
    return emits;
  endfunction

  task automatic report_mismatch(input string field, input word_t got, input word_t want);
    if (errors < 40) $display("checker: %s mismatch, got %h, expected %h", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    display_word_t fresh;
    display_word_t oldest;
    if (!rst_n) begin
      src_wide = 1'b0;
      row_halving = 1'b0;
      mask_luma_a = 32'hFF00_0000;
      mask_luma_b = 32'h0000_FF00;
      mask_chroma = 32'h00FF_00FF;
      pair_first = '0;
      pair_open = 1'b0;
      col_pos = 0;
      row_pos = 0;
      display_due.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_WIDE:      src_wide = cfg_wdata[0];
          REG_HALVE_ROWS:       row_halving = cfg_wdata[0];
          REG_LUMA_FIRST_MASK:  mask_luma_a = cfg_wdata;
          REG_LUMA_SECOND_MASK: mask_luma_b = cfg_wdata;
          REG_CHROMA_MASK:      mask_chroma = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (predict_display_word(in_tdata, in_tuser, fresh)) display_due.push_back(fresh);
      end
      if (out_tvalid && out_tready) begin
        if (display_due.size() == 0) begin
          report_mismatch("unrequested out_word", out_tdata, '0);
        end else begin
          oldest = display_due.pop_front();
          if (out_tdata !== oldest.word) report_mismatch("out_word", out_tdata, oldest.word);
          if (out_tlast !== oldest.last) begin
            report_mismatch("last_in_frame", word_t'(out_tlast), word_t'(oldest.last));
          end
        end
      end
      outstanding <= display_due.size();
    end
  end

endmodule

### tb/testbench.sv
// Testbench top for the YUY2 frame downscale mixer: clock, reset, request stimulus,
// output pacing and the verdict. Depends on yfdm_pkg, the mixer RTL and
// yfdm_display_checker.
module testbench;
  import yfdm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);
  localparam int    SETTLE_CYCLES = 6;
  localparam int    IDLE_LIMIT    = 3000;
  localparam int    PRESSURE_AT   = 150;
  localparam int    HOLD_OFF      = 400;
  localparam int    SWEEP_WORDS   = 150;
  localparam word_t LUMA_A_RESET  = 32'hFF00_0000;
  localparam word_t LUMA_B_RESET  = 32'h0000_FF00;
  localparam word_t CHROMA_RESET  = 32'h00FF_00FF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t                cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  word_t                in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  word_t                out_tdata;
  logic                 out_tlast;

  logic        fast_pace = 1'b0;
  int unsigned feed_calm = 0;
  int unsigned stall_count = 0;
  int          outstanding;
  int          errors;

  always #4 clk = ~clk;

  yuy2_frame_downscale_mixer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  yfdm_display_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .outstanding (outstanding),
    .errors      (errors)
  );

  // Idle cycles before the next request; calm stretches run with no idling.
  function automatic int unsigned pick_gap(input bit quick, inout int unsigned calm);
    if (quick) return ($urandom_range(0, 31) == 0) ? $urandom_range(1, 14) : 0;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 50);
    return $urandom_range(0, 14);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input word_t w, input logic start);
    int unsigned gap;
    gap = pick_gap(fast_pace, feed_calm);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted word has come out and the pipe is empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_modes(input logic wide, input logic halve, input word_t luma_a,
                           input word_t luma_b, input word_t chroma);
    word_t junk;
    drain();
    // Upper bits of the mode registers are don't-care; fill them with noise.
    junk = $urandom();
    junk[0] = wide;
    cfg_write(REG_SOURCE_WIDE, junk);
    junk = $urandom();
    junk[0] = halve;
    cfg_write(REG_HALVE_ROWS, junk);
    cfg_write(REG_LUMA_FIRST_MASK, luma_a);
    cfg_write(REG_LUMA_SECOND_MASK, luma_b);
    cfg_write(REG_CHROMA_MASK, chroma);
  endtask

  // start_odds of 0 keeps frame_start off after the first word.
  task automatic run_random(input int count, input logic first_start, input int start_odds);
    logic start;
    for (int i = 0; i < count; i++) begin
      if (i == 0) start = first_start;
      else start = (start_odds != 0) && ($urandom_range(1, start_odds) == 1);
      send_word(pick_word(), start);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pass-through at reset settings, field extremes
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0);

    // Pair merge with default masks; a frame start in mid-pair drops the held word
    drain();
    cfg_write(REG_SOURCE_WIDE, 32'h0000_0001);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h9ABC_DEF0, 1'b1);
    send_word(32'h0F0F_0F0F, 1'b0);

    // Overlapping all-ones masks, then all-zero masks
    drain();
    cfg_write(REG_LUMA_FIRST_MASK, '1);
    cfg_write(REG_LUMA_SECOND_MASK, '1);
    cfg_write(REG_CHROMA_MASK, '1);
    cfg_write(REG_SPARE, $urandom());
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    drain();
    cfg_write(REG_LUMA_FIRST_MASK, '0);
    cfg_write(REG_LUMA_SECOND_MASK, '0);
    cfg_write(REG_CHROMA_MASK, '0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);

    // Fill the line store with a whole even row before any odd row reads it
    set_modes(1'b0, 1'b1, LUMA_A_RESET, LUMA_B_RESET, CHROMA_RESET);
    run_random(400, 1'b1, 0);
    // Switch to wide source in mid odd row
    set_modes(1'b1, 1'b1, $urandom(), $urandom(), $urandom());
    run_random(240, 1'b0, 0);
    set_modes(1'b1, 1'b0, $urandom(), '0, $urandom());
    run_random(200, 1'b0, 50);
    set_modes(1'b0, 1'b0, '1, '1, '1);
    run_random(150, 1'b1, 50);
    set_modes(1'b0, 1'b1, $urandom(), $urandom(), $urandom());
    run_random(100, 1'b0, 0);

    // Mostly back-to-back pass-through burst with both sides at the fast pace
    set_modes(1'b0, 1'b0, LUMA_A_RESET, LUMA_B_RESET, CHROMA_RESET);
    fast_pace <= 1'b1;
    for (int i = 0; i < SWEEP_WORDS; i++) send_word($urandom(), i == 0);
    drain();

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : sink
    int unsigned gap;
    int unsigned calm;
    int unsigned taken;
    calm = 0;
    taken = 0;
    @(posedge clk iff rst_n);
    forever begin
      // Hold off once for a long stretch so the block backs up into its input
      if (taken == PRESSURE_AT) gap = HOLD_OFF;
      else gap = pick_gap(fast_pace, calm);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else if (stall_count == IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule

### files.f
hw/rtl/yfdm_pkg.sv
hw/rtl/yfdm_ram.sv
hw/rtl/yuy2_frame_downscale_mixer.sv
tb/yfdm_display_checker.sv
tb/testbench.sv
